>>> hdl/swdb_pkg.sv
// shared types and constants for the debounced toggle switch
`timescale 1ns / 1ps

package swdb_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_SWITCH_MODE    = 3'd0;
  localparam logic [2:0] REG_INVERT_INPUT   = 3'd1;
  localparam logic [2:0] REG_BOUNCE_MS      = 3'd2;
  localparam logic [2:0] REG_BLINK_INTERVAL = 3'd3;
  localparam logic [2:0] REG_REST_LEVEL     = 3'd4;

  localparam logic        SWITCH_MODE_RST    = 1'b0;
  localparam logic        INVERT_INPUT_RST   = 1'b0;
  localparam logic [15:0] BOUNCE_MS_RST      = 16'd50;
  localparam logic [15:0] BLINK_INTERVAL_RST = 16'd1000;
  localparam logic        REST_LEVEL_RST     = 1'b0;

  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        toggle_state;
    logic        physical_level;
    logic        press_event;
    logic        physical_event;
    logic        release_event;
    logic [31:0] hold_ms;
    logic        led_on;
  } out_item_t;

  typedef struct packed {
    logic        switch_mode;
    logic        invert_input;
    logic [15:0] bounce_ms;
    logic [15:0] blink_interval_ms;
  } cfg_t;

  // what the debounce logic asks of the blink unit for one beat
  typedef struct packed {
    logic press;
    logic step;
    logic release_hit;
  } led_ctl_t;

endpackage

>>> hdl/swdb_cfg.sv
// apb-style configuration registers
`timescale 1ns / 1ps

module swdb_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [swdb_pkg::ADDR_W-1:0] paddr,
  input  logic [swdb_pkg::DATA_W-1:0] pwdata,
  output logic [swdb_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output swdb_pkg::cfg_t             cfg
);
  import swdb_pkg::*;

  logic        switch_mode_r;
  logic        invert_input_r;
  logic [15:0] bounce_ms_r;
  logic [15:0] blink_interval_r;
  logic        rest_level_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      switch_mode_r    <= SWITCH_MODE_RST;
      invert_input_r   <= INVERT_INPUT_RST;
      bounce_ms_r      <= BOUNCE_MS_RST;
      blink_interval_r <= BLINK_INTERVAL_RST;
      rest_level_r     <= REST_LEVEL_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SWITCH_MODE:    switch_mode_r    <= pwdata[0];
        REG_INVERT_INPUT:   invert_input_r   <= pwdata[0];
        REG_BOUNCE_MS:      bounce_ms_r      <= pwdata[15:0];
        REG_BLINK_INTERVAL: blink_interval_r <= pwdata[15:0];
        REG_REST_LEVEL:     rest_level_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_SWITCH_MODE:    prdata = {31'd0, switch_mode_r};
      REG_INVERT_INPUT:   prdata = {31'd0, invert_input_r};
      REG_BOUNCE_MS:      prdata = {16'd0, bounce_ms_r};
      REG_BLINK_INTERVAL: prdata = {16'd0, blink_interval_r};
      REG_REST_LEVEL:     prdata = {31'd0, rest_level_r};
      default:            prdata = '0;
    endcase
  end

  assign cfg.switch_mode       = switch_mode_r;
  assign cfg.invert_input      = invert_input_r;
  assign cfg.bounce_ms         = bounce_ms_r;
  assign cfg.blink_interval_ms = blink_interval_r;

endmodule

>>> hdl/swdb_led.sv
// hold indication blink unit: burst counters and lamp state
`timescale 1ns / 1ps

module swdb_led #(
  parameter int BLINK_ON_MS     = 100,
  parameter int BLINK_PERIOD_MS = 200,
  parameter int COUNT_WIDTH     = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  swdb_pkg::led_ctl_t   ctl,
  input  logic [31:0]          now_ms,
  input  logic [15:0]          blink_interval_ms,
  output logic                 lamp_nxt
);
  import swdb_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [31:0]            hold_start_r, hold_start_nxt;
  logic [31:0]            burst_start_r, burst_start_nxt;
  logic [COUNT_WIDTH-1:0] interval_cnt_r, interval_cnt_nxt;
  logic [COUNT_WIDTH-1:0] blink_cnt_r, blink_cnt_nxt;
  logic                   burst_active_r, burst_active_nxt;
  logic                   lamp_r;

  logic [31:0]            hs_eff;
  logic [COUNT_WIDTH-1:0] ic_eff, bc_eff, ic1;
  logic                   ba_eff, ba1, lamp_eff, lamp1, lamp2, ba2;
  logic [31:0]            bs1;
  logic [31:0]            since_hold, since_burst;
  logic [COUNT_WIDTH+15:0] ivl_prod;
  logic [31:0]            per_prod, per_prod1, off_at;
  logic                   new_burst, turn_off;
  logic [COUNT_WIDTH:0]   bc_inc;
  logic [COUNT_WIDTH-1:0] bc2;

  always_comb begin
    // a press restarts the hold measurement before the blink step
    hs_eff   = ctl.press ? now_ms : hold_start_r;
    ic_eff   = ctl.press ? '0 : interval_cnt_r;
    bc_eff   = ctl.press ? '0 : blink_cnt_r;
    ba_eff   = ctl.press ? 1'b0 : burst_active_r;
    lamp_eff = lamp_r;

    since_hold = now_ms - hs_eff;
    ivl_prod   = ic_eff * blink_interval_ms;
    new_burst  = (ic_eff != CNT_MAX) && (since_hold >= 32'(ivl_prod));

    ic1 = new_burst ? ic_eff + 1'b1 : ic_eff;
    bs1 = new_burst ? now_ms : burst_start_r;
    ba1 = new_burst ? 1'b1 : ba_eff;

    // blink count is cleared by a new burst, so its product is too
    per_prod    = 32'(bc_eff) * 32'(BLINK_PERIOD_MS);
    per_prod1   = new_burst ? 32'd0 : per_prod;
    since_burst = now_ms - bs1;
    off_at      = per_prod1 + 32'(BLINK_ON_MS);

    lamp1    = lamp_eff || (ba1 && (since_burst >= per_prod1));
    turn_off = lamp1 && (since_burst >= off_at);
    bc_inc   = {1'b0, (new_burst ? '0 : bc_eff)} + 1'b1;

    lamp2 = lamp1;
    ba2   = ba1;
    bc2   = new_burst ? '0 : bc_eff;
    if (turn_off) begin
      lamp2 = 1'b0;
      if (bc_inc >= {1'b0, ic1}) begin
        ba2 = 1'b0;
        bc2 = '0;
      end else begin
        bc2 = bc_inc[COUNT_WIDTH-1:0];
      end
    end

    hold_start_nxt   = hold_start_r;
    burst_start_nxt  = burst_start_r;
    interval_cnt_nxt = interval_cnt_r;
    blink_cnt_nxt    = blink_cnt_r;
    burst_active_nxt = burst_active_r;
    lamp_nxt         = lamp_r;
    if (ctl.release_hit) begin
      hold_start_nxt   = '0;
      burst_start_nxt  = '0;
      interval_cnt_nxt = '0;
      blink_cnt_nxt    = '0;
      burst_active_nxt = 1'b0;
      lamp_nxt         = 1'b0;
    end else if (ctl.step) begin
      hold_start_nxt   = hs_eff;
      burst_start_nxt  = bs1;
      interval_cnt_nxt = ic1;
      blink_cnt_nxt    = bc2;
      burst_active_nxt = ba2;
      lamp_nxt         = lamp2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_start_r   <= '0;
      burst_start_r  <= '0;
      interval_cnt_r <= '0;
      blink_cnt_r    <= '0;
      burst_active_r <= 1'b0;
      lamp_r         <= 1'b0;
    end else if (fire) begin
      hold_start_r   <= hold_start_nxt;
      burst_start_r  <= burst_start_nxt;
      interval_cnt_r <= interval_cnt_nxt;
      blink_cnt_r    <= blink_cnt_nxt;
      burst_active_r <= burst_active_nxt;
      lamp_r         <= lamp_nxt;
    end
  end

endmodule

>>> hdl/swdb_core.sv
// input register, debounce and toggle logic, result register
`timescale 1ns / 1ps

module swdb_core #(
  parameter int BLINK_ON_MS     = 100,
  parameter int BLINK_PERIOD_MS = 200,
  parameter int COUNT_WIDTH     = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  swdb_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  swdb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output swdb_pkg::out_item_t out_data
);
  import swdb_pkg::*;

  in_item_t  s1_data_r;
  logic      s1_valid_r;
  out_item_t out_data_r, out_nxt;
  logic      out_valid_r;
  logic      advance, fire;

  logic        toggled_r, toggled_nxt;
  logic        last_level_r, last_level_nxt;
  logic        accepted_r, accepted_nxt;
  logic        timer_run_r, timer_run_nxt;
  logic [31:0] timer_start_r, timer_start_nxt;
  logic        held_latch_r, held_latch_nxt;

  logic        cur;
  logic [31:0] now;
  logic [31:0] ts_eff, elapsed;
  led_ctl_t    led_ctl;
  logic        lamp_nxt;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  always_comb begin
    cur = s1_data_r.pin_level ^ cfg.invert_input;
    now = s1_data_r.now_ms;

    toggled_nxt     = toggled_r;
    last_level_nxt  = last_level_r;
    accepted_nxt    = accepted_r;
    timer_run_nxt   = timer_run_r;
    timer_start_nxt = timer_start_r;
    held_latch_nxt  = held_latch_r;
    led_ctl         = '0;

    out_nxt                = '0;

    ts_eff  = timer_run_r ? timer_start_r : now;
    elapsed = now - ts_eff;

    if (cur != last_level_r) begin
      timer_run_nxt   = 1'b1;
      timer_start_nxt = ts_eff;
      if (elapsed >= {16'd0, cfg.bounce_ms}) begin
        if (cfg.switch_mode) begin
          if (!held_latch_r) begin
            toggled_nxt         = !toggled_r;
            held_latch_nxt      = 1'b1;
            out_nxt.press_event = 1'b1;
            out_nxt.physical_event = 1'b1;
            accepted_nxt        = cur;
            led_ctl.press       = 1'b1;
          end
          led_ctl.step = 1'b1;
        end else begin
          toggled_nxt            = !toggled_r;
          last_level_nxt         = cur;
          out_nxt.press_event    = 1'b1;
          out_nxt.physical_event = 1'b1;
          accepted_nxt           = cur;
          timer_run_nxt          = 1'b0;
        end
      end
    end else if (timer_run_r && cfg.switch_mode) begin
      // return to the rest level ends the press, glitches included
      out_nxt.release_event  = 1'b1;
      out_nxt.hold_ms        = (elapsed <= {16'd0, cfg.bounce_ms}) ? 32'd0 : elapsed;
      out_nxt.physical_event = 1'b1;
      led_ctl.release_hit    = 1'b1;
      timer_run_nxt          = 1'b0;
      held_latch_nxt         = 1'b0;
      accepted_nxt           = cur;
    end

    out_nxt.toggle_state   = toggled_nxt;
    out_nxt.physical_level = accepted_nxt;
    out_nxt.led_on         = lamp_nxt;
  end

  swdb_led #(
    .BLINK_ON_MS    (BLINK_ON_MS),
    .BLINK_PERIOD_MS(BLINK_PERIOD_MS),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_led (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (fire),
    .ctl              (led_ctl),
    .now_ms           (now),
    .blink_interval_ms(cfg.blink_interval_ms),
    .lamp_nxt         (lamp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      toggled_r     <= REST_LEVEL_RST;
      last_level_r  <= REST_LEVEL_RST;
      accepted_r    <= REST_LEVEL_RST;
      timer_run_r   <= 1'b0;
      timer_start_r <= '0;
      held_latch_r  <= 1'b0;
    end else begin
      if (!s1_valid_r || advance) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire) begin
        toggled_r     <= toggled_nxt;
        last_level_r  <= last_level_nxt;
        accepted_r    <= accepted_nxt;
        timer_run_r   <= timer_run_nxt;
        timer_start_r <= timer_start_nxt;
        held_latch_r  <= held_latch_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/switch_debounce_toggle_hold.sv
// top level of the debounced toggle switch with hold time and blink indication
`timescale 1ns / 1ps

// One pin sample with a millisecond timestamp enters per beat and yields exactly one
// result beat. The block takes a new sample every clock cycle unless in_stall is
// raised by a stalled output; a sample's result passes through the input register
// and then the result register, with all debounce, toggle, hold-time and blink work
// done in one pass between them. The longest path is the
// interval-count-by-blink-interval product and its compare. Time arithmetic wraps
// modulo 2^32. Registers sit on an apb-style port at byte addresses 0, 4, 8, 12 and
// 16 (switch_mode, invert_input, bounce_ms, blink_interval_ms, rest_level); write
// them only while no sample is in flight. rest_level only reads back, the switch
// state after reset is always level 0.
module switch_debounce_toggle_hold #(
  parameter int BLINK_ON_MS     = 100,
  parameter int BLINK_PERIOD_MS = 200,
  parameter int COUNT_WIDTH     = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  swdb_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output swdb_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swdb_pkg::ADDR_W-1:0] paddr,
  input  logic [swdb_pkg::DATA_W-1:0] pwdata,
  output logic [swdb_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import swdb_pkg::*;

  cfg_t cfg;

  swdb_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  swdb_core #(
    .BLINK_ON_MS    (BLINK_ON_MS),
    .BLINK_PERIOD_MS(BLINK_PERIOD_MS),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
